// ===== sv/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants for the linear-probing hash table: field widths,
// operation and status codes, and the layout of one table entry.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W  = 31;
    localparam int DATA_W = 32;
    localparam int SLOT_W = 4;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [DATA_W-1:0] data_t;

    // One table entry as held in the slot memory.
    typedef struct packed {
        logic  used;
        key_t  key;
        data_t data;
    } entry_t;

endpackage

// ===== sv/linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing hash table with linear probing, held in one synchronous
// slot memory.
// ----------------------------------------------------------------------------
// Usage: raise start with operation, key and data_in while busy is low; the
// beat is taken at that clock edge. Exactly one result follows, shown on
// status, data_out and slot for a single cycle with done high. The receiver
// cannot stall the block, so the result must be captured in that cycle.
// After reset the block clears the occupied marks, one slot per cycle, and
// holds busy high while that sweep runs. After the accepting edge an item
// passes through S_MUL, S_SCALE and S_HOME, which work out the home slot
// (key mod TABLE_SLOTS by reciprocal multiply, a second multiply, and one
// correcting subtract), then S_PROBE, which probes 1 to TABLE_SLOTS slots;
// the probing is set by the single read port of the slot memory, which
// yields one probed slot a cycle. A new item is taken only back in S_IDLE.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // command beat
    input  logic                        start,
    output logic                        busy,
    input  logic                        operation,
    input  logic [lpht_pkg::KEY_W-1:0]  key,
    input  logic [lpht_pkg::DATA_W-1:0] data_in,
    // result beat
    output logic                        done,
    output logic [1:0]                  status,
    output logic [lpht_pkg::DATA_W-1:0] data_out,
    output logic [lpht_pkg::SLOT_W-1:0] slot
);
    import lpht_pkg::*;

    // Slot index width and the slot count at that width (plus one bit).
    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_C  = (IDX_W+1)'(TABLE_SLOTS);

    // Reciprocal for key mod TABLE_SLOTS. With M = floor(2^32 / N) and a
    // key below 2^31, (key * M) >> 32 is the true quotient or one less, so
    // the remainder lands in [0, 2N) and one subtract fixes it.
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / TABLE_SLOTS);
    localparam int PROD_W = KEY_W + RECIP_W;
    localparam int QN_W   = KEY_W + IDX_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,    // sweep occupied marks after reset
        S_IDLE,
        S_MUL,      // key times reciprocal
        S_SCALE,    // estimated quotient times slot count
        S_HOME,     // remainder, first read issued
        S_PROBE     // one slot examined per cycle
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  clr_reg;
    op_t               op_reg;
    key_t              key_reg;
    data_t             data_reg;
    logic [PROD_W-1:0] prod_reg;
    key_t              qn_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic              done_reg;
    status_t           status_reg;
    data_t             data_out_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Slot memory: one write port, one registered read port.
    entry_t            mem [TABLE_SLOTS];
    entry_t            rd_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_word;
    logic [IDX_W-1:0]  rd_addr;

    // Datapath helpers.
    logic [PROD_W-1:0]       prod_next;
    key_t                    quot;
    logic [QN_W-1:0]         qn_full;
    key_t                    rem_raw;
    key_t                    rem_fix;
    logic [IDX_W-1:0]        home_idx;
    logic [IDX_W-1:0]        pos_next;
    logic                    last_probe;
    logic                    key_hit;
    logic [IDX_W+SLOT_W-1:0] pos_wide;

    assign prod_next = PROD_W'(key_reg) * PROD_W'(RECIP);
    assign quot      = prod_reg[PROD_W-1 -: KEY_W];
    assign qn_full   = QN_W'(quot) * QN_W'(SLOTS_C);
    assign rem_raw   = key_reg - qn_reg;
    assign rem_fix   = (rem_raw >= KEY_W'(TABLE_SLOTS))
                     ? rem_raw - KEY_W'(TABLE_SLOTS) : rem_raw;
    assign home_idx  = rem_fix[IDX_W-1:0];

    assign pos_next   = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
    assign last_probe = (cnt_reg == LAST_IDX);
    assign key_hit    = rd_reg.used && (rd_reg.key == key_reg);
    assign pos_wide   = {{SLOT_W{1'b0}}, pos_reg};

    // Read the home slot in S_HOME, the following slot while probing.
    assign rd_addr = (state_reg == S_HOME) ? home_idx : pos_next;

    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_word.used    = 1'b1;
        wr_word.key     = key_reg;
        wr_word.data    = data_reg;
        if (state_reg == S_CLEAR)
        begin
            wr_en        = 1'b1;
            wr_addr      = clr_reg;
            wr_word.used = 1'b0;
        end
        else if (state_reg == S_PROBE && op_reg == OP_INSERT && !rd_reg.used)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        rd_reg <= mem[rd_addr];
    end

    // Control and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= op_t'(operation);
                        key_reg   <= key;
                        data_reg  <= data_in;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    qn_reg    <= qn_full[KEY_W-1:0];
                    state_reg <= S_HOME;
                end
                S_HOME:
                begin
                    pos_reg   <= home_idx;
                    cnt_reg   <= '0;
                    state_reg <= S_PROBE;
                end
                S_PROBE:
                begin
                    pos_reg <= pos_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (op_reg == OP_INSERT)
                    begin
                        if (!rd_reg.used)
                        begin
                            done_reg     <= 1'b1;
                            status_reg   <= ST_INSERTED;
                            data_out_reg <= '0;
                            slot_reg     <= pos_wide[SLOT_W-1:0];
                            state_reg    <= S_IDLE;
                        end
                        else if (last_probe)
                        begin
                            done_reg     <= 1'b1;
                            status_reg   <= ST_FULL;
                            data_out_reg <= '0;
                            slot_reg     <= '0;
                            state_reg    <= S_IDLE;
                        end
                    end
                    else
                    begin
                        if (key_hit)
                        begin
                            done_reg     <= 1'b1;
                            status_reg   <= ST_FOUND;
                            data_out_reg <= rd_reg.data;
                            slot_reg     <= pos_wide[SLOT_W-1:0];
                            state_reg    <= S_IDLE;
                        end
                        else if (!rd_reg.used || last_probe)
                        begin
                            done_reg     <= 1'b1;
                            status_reg   <= ST_MISSING;
                            data_out_reg <= '0;
                            slot_reg     <= '0;
                            state_reg    <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign data_out = data_out_reg;
    assign slot     = slot_reg;

endmodule
